### rtl/bcds_pkg.sv
// Shared constants, types and helpers for the bitcrusher and sample-rate reducer.
`timescale 1ns / 1ps

package bcds_pkg;

    localparam int SAMPLE_W = 24;
    localparam int ACC_W    = 48;
    localparam int MUL_W    = 22;
    localparam int DEN_W    = 21;
    localparam int WET_W    = 36;
    localparam int CNT_W    = $clog2(ACC_W);

    localparam logic [31:0] LFSR_SEED = 32'hACE12468;
    localparam logic [31:0] LFSR_MASK = 32'h80200003;

    localparam logic [14:0] ONE_Q8     = 15'd256;
    localparam logic [14:0] MAX_RATE   = 15'd16384;
    localparam logic [4:0]  MAX_DEPTH  = 5'd24;
    localparam logic [6:0]  PCT_FULL   = 7'd100;
    localparam logic [DEN_W-1:0] DEN_PCT   = DEN_W'(100);
    localparam logic [DEN_W-1:0] DEN_FINAL = DEN_W'(1638400);

    localparam logic [2:0] REG_FLOW_MODE     = 3'd0;
    localparam logic [2:0] REG_OUTPUT_MIX    = 3'd1;
    localparam logic [2:0] REG_OUTPUT_GAIN   = 3'd2;
    localparam logic [2:0] REG_DS_FACTOR     = 3'd3;
    localparam logic [2:0] REG_DS_MIX        = 3'd4;
    localparam logic [2:0] REG_CRUSH_DEPTH   = 3'd5;
    localparam logic [2:0] REG_CRUSH_MIX     = 3'd6;
    localparam logic [2:0] REG_FEATURE_FLAGS = 3'd7;

    localparam logic [1:0] FLOW_HOLD_FIRST = 2'd1;
    localparam logic [1:0] FLOW_PARALLEL   = 2'd2;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2**(SAMPLE_W-1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    typedef enum logic [1:0] {
        MDU_LOAD,
        MDU_MAC,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic                     valid;
        t_mdu_op                  op;
        logic signed [ACC_W-1:0]  a;
        logic [MUL_W-1:0]         b;
        logic [DEN_W-1:0]         den;
    } t_mdu_req;

    function automatic logic signed [SAMPLE_W-1:0] sat_s(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        begin
            if (v > SAT_HI) begin
                c = SAT_HI;
            end else if (v < SAT_LO) begin
                c = SAT_LO;
            end else begin
                c = v;
            end
            return c[SAMPLE_W-1:0];
        end
    endfunction

    function automatic logic [6:0] pct_clamp(input logic [6:0] p);
        return (p > PCT_FULL) ? PCT_FULL : p;
    endfunction

endpackage

### rtl/bcds_mdu.sv
// Bit-serial multiply-accumulate and rounding divide unit.
`timescale 1ns / 1ps

module bcds_mdu (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bcds_pkg::t_mdu_req                     i_req,
    output logic                                   o_busy,
    output logic signed [bcds_pkg::ACC_W-1:0]      o_acc
);
    import bcds_pkg::*;

    typedef enum logic [1:0] {
        M_IDLE,
        M_MAC,
        M_DIV,
        M_FIX
    } t_mstate;

    t_mstate                  r_state;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_mcand;
    logic [MUL_W-1:0]         r_mplier;
    logic [DEN_W-1:0]         r_den;
    logic [DEN_W-1:0]         r_rem;
    logic                     r_neg;
    logic [CNT_W-1:0]         r_cnt;

    logic [DEN_W:0]           w_t;
    logic [DEN_W:0]           w_diff;
    logic                     w_ge;
    logic signed [ACC_W-1:0]  w_mag;

    always_comb begin
        w_t    = {r_rem, r_acc[ACC_W-1]};
        w_diff = w_t - {1'b0, r_den};
        w_ge   = (w_t >= {1'b0, r_den});
        w_mag  = (r_acc < 0) ? -r_acc : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                M_IDLE: begin
                    if (i_req.valid) begin
                        unique case (i_req.op)
                            MDU_LOAD: begin
                                r_acc <= i_req.a;
                            end
                            MDU_MAC: begin
                                r_mcand  <= i_req.a;
                                r_mplier <= i_req.b;
                                r_cnt    <= CNT_W'(MUL_W - 1);
                                r_state  <= M_MAC;
                            end
                            MDU_DIV: begin
                                // Divide the magnitude plus half the divisor, restore sign later.
                                r_neg   <= (r_acc < 0);
                                r_acc   <= w_mag + ACC_W'(i_req.den >> 1);
                                r_den   <= i_req.den;
                                r_rem   <= '0;
                                r_cnt   <= CNT_W'(ACC_W - 1);
                                r_state <= M_DIV;
                            end
                            default: begin
                                r_state <= M_IDLE;
                            end
                        endcase
                    end
                end
                M_MAC: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= r_mcand <<< 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= M_IDLE;
                    end
                end
                M_DIV: begin
                    r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_t[DEN_W-1:0];
                    r_acc <= {r_acc[ACC_W-2:0], w_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= M_FIX;
                    end
                end
                M_FIX: begin
                    if (r_neg) begin
                        r_acc <= -r_acc;
                    end
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != M_IDLE);
    assign o_acc  = r_acc;

endmodule

### rtl/bitcrush_downsample_effect_core.sv
// Top level of the bitcrusher and sample-rate reducer: sequencer, state and ports.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  input   | in        | i_in_valid / o_in_stall   | i_sample_in (24b signed)
//  output  | out       | o_out_valid / i_out_stall | o_sample_out (24b signed)
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// When the effect is bypassed an item goes straight to the output stage; otherwise
// it is worked by the shared bit-serial unit, which runs up to nine multiplies and
// rounding divides per item.
// Reset is synchronous and active low; it restores register defaults and the state.
// A finished item waits in the output register while the next item is accepted.
`timescale 1ns / 1ps

module bitcrush_downsample_effect_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [bcds_pkg::SAMPLE_W-1:0]  i_sample_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [bcds_pkg::SAMPLE_W-1:0]  o_sample_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [2:0]                            i_cfg_index,
    input  logic [15:0]                           i_cfg_data
);
    import bcds_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_STAGE,
        S_CRUSH,
        S_HOLD,
        S_INT_LD,
        S_INT_MAC,
        S_INT_DIV,
        S_INT_END,
        S_PCT_LD,
        S_PCT_MAC,
        S_PCT_DIV,
        S_PCT_END,
        S_STAGE_END,
        S_FIN_LD,
        S_FIN_M1,
        S_FIN_M2,
        S_FIN_DIV,
        S_FIN_END,
        S_OUT,
        S_WAIT
    } t_state;

    // Configuration registers.
    logic [1:0]  r_flow_mode;
    logic [6:0]  r_output_mix;
    logic [14:0] r_output_gain;
    logic [14:0] r_ds_factor;
    logic [6:0]  r_ds_mix;
    logic [4:0]  r_crush_depth;
    logic [6:0]  r_crush_mix;
    logic [1:0]  r_feature_flags;

    // Effect state.
    logic [14:0]                 r_phase;
    logic signed [SAMPLE_W-1:0]  r_held;
    logic [31:0]                 r_lfsr;

    // Sequencer.
    t_state                      r_state;
    t_state                      r_ret;
    t_mdu_req                    r_req;
    logic                        r_pass;
    logic signed [SAMPLE_W-1:0]  r_x;
    logic signed [SAMPLE_W-1:0]  r_v;
    logic signed [SAMPLE_W-1:0]  r_y;
    logic signed [SAMPLE_W-1:0]  r_a;
    logic signed [SAMPLE_W-1:0]  r_res;
    logic signed [WET_W-1:0]     r_wet;
    logic [6:0]                  r_pm;
    logic [14:0]                 r_c0;
    logic [MUL_W-1:0]            r_g;
    logic                        r_ov;
    logic signed [SAMPLE_W-1:0]  r_out;

    logic                        w_busy;
    logic signed [ACC_W-1:0]     w_acc;

    // Crush datapath.
    logic [4:0]                  w_d;
    logic [4:0]                  w_k;
    logic signed [SAMPLE_W:0]    w_vx;
    logic [SAMPLE_W:0]           w_mag;
    logic [SAMPLE_W:0]           w_lowmask;
    logic [SAMPLE_W:0]           w_half;
    logic [SAMPLE_W:0]           w_qm;
    logic signed [SAMPLE_W+1:0]  w_q;
    logic signed [SAMPLE_W+1:0]  w_dith;
    logic [31:0]                 w_lfsr_nx;
    logic signed [WET_W-1:0]     w_cwet;

    // Hold datapath.
    logic [14:0]                 w_rate;
    logic                        w_hold_bypass;
    logic [15:0]                 w_pc;
    logic                        w_capture;

    // Mix helpers.
    logic signed [ACC_W-1:0]     w_v100;
    logic signed [ACC_W-1:0]     w_pct_a;
    logic signed [ACC_W-1:0]     w_int_a;
    logic signed [WET_W-1:0]     w_int_wet;
    logic signed [SAMPLE_W+1:0]  w_sum;
    logic signed [SAMPLE_W+1:0]  w_avg;
    logic [6:0]                  w_p;
    logic [MUL_W-1:0]            w_g;
    logic                        w_hold_stage;
    logic                        w_parallel;

    bcds_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_busy  (w_busy),
        .o_acc   (w_acc)
    );

    always_comb begin
        w_parallel   = (r_flow_mode == FLOW_PARALLEL);
        // First pass runs the hold stage only when hold comes first.
        w_hold_stage = (r_flow_mode == FLOW_HOLD_FIRST) ? !r_pass : r_pass;

        w_d       = (r_crush_depth > MAX_DEPTH) ? MAX_DEPTH : r_crush_depth;
        w_k       = MAX_DEPTH - w_d;
        w_vx      = {r_v[SAMPLE_W-1], r_v};
        w_mag     = (w_vx < 0) ? unsigned'(-w_vx) : unsigned'(w_vx);
        w_lowmask = ((SAMPLE_W+1)'(1) << w_k) - (SAMPLE_W+1)'(1);
        w_half    = (w_k == '0) ? '0 : ((SAMPLE_W+1)'(1) << (w_k - 5'd1));
        w_qm      = (w_mag + w_half) & ~w_lowmask;
        w_q       = r_v[SAMPLE_W-1] ? -signed'({1'b0, w_qm}) : signed'({1'b0, w_qm});
        w_lfsr_nx = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_MASK : 32'd0);
        if (r_feature_flags[1]) begin
            w_dith = signed'({1'b0, w_lfsr_nx[SAMPLE_W:0] & w_lowmask})
                   - signed'({1'b0, w_half});
        end else begin
            w_dith = '0;
        end
        w_cwet = WET_W'(w_q + w_dith);

        w_rate        = (r_ds_factor > MAX_RATE) ? MAX_RATE : r_ds_factor;
        w_hold_bypass = (r_ds_factor <= ONE_Q8) || (r_ds_mix == '0);
        w_pc          = {1'b0, r_phase} + {1'b0, ONE_Q8};
        w_capture     = (w_pc >= {1'b0, w_rate});

        w_v100    = (ACC_W'(r_v) <<< 6) + (ACC_W'(r_v) <<< 5) + (ACC_W'(r_v) <<< 2);
        w_pct_a   = ACC_W'(r_wet - WET_W'(r_v));
        w_int_a   = ACC_W'(r_held) - ACC_W'(r_v);
        w_int_wet = WET_W'(r_v) + WET_W'(w_acc);

        // Two guard bits keep the negated sum of two full-scale negatives in range.
        w_sum = (SAMPLE_W+2)'(r_a) + (SAMPLE_W+2)'(r_y);
        if (w_sum >= 0) begin
            w_avg = (w_sum + (SAMPLE_W+2)'(1)) >>> 1;
        end else begin
            w_avg = -((-w_sum + (SAMPLE_W+2)'(1)) >>> 1);
        end

        w_p = pct_clamp(r_output_mix);
        w_g = MUL_W'(r_output_gain) * MUL_W'(w_p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_mode     <= 2'd0;
            r_output_mix    <= PCT_FULL;
            r_output_gain   <= 15'd16384;
            r_ds_factor     <= ONE_Q8;
            r_ds_mix        <= PCT_FULL;
            r_crush_depth   <= MAX_DEPTH;
            r_crush_mix     <= PCT_FULL;
            r_feature_flags <= 2'd0;
            r_phase         <= '0;
            r_held          <= '0;
            r_lfsr          <= LFSR_SEED;
            r_state         <= S_IDLE;
            r_ret           <= S_IDLE;
            r_req           <= '0;
            r_pass          <= 1'b0;
            r_ov            <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_FLOW_MODE:     r_flow_mode     <= i_cfg_data[1:0];
                    REG_OUTPUT_MIX:    r_output_mix    <= i_cfg_data[6:0];
                    REG_OUTPUT_GAIN:   r_output_gain   <= i_cfg_data[14:0];
                    REG_DS_FACTOR:     r_ds_factor     <= i_cfg_data[14:0];
                    REG_DS_MIX:        r_ds_mix        <= i_cfg_data[6:0];
                    REG_CRUSH_DEPTH:   r_crush_depth   <= i_cfg_data[4:0];
                    REG_CRUSH_MIX:     r_crush_mix     <= i_cfg_data[6:0];
                    REG_FEATURE_FLAGS: r_feature_flags <= i_cfg_data[1:0];
                    default:           r_flow_mode     <= r_flow_mode;
                endcase
            end

            if (r_ov && !i_out_stall && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x    <= i_sample_in;
                        r_v    <= i_sample_in;
                        r_pass <= 1'b0;
                        r_g    <= w_g;
                        if (r_output_mix == '0) begin
                            r_res   <= i_sample_in;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_STAGE;
                        end
                    end
                end
                S_STAGE: begin
                    r_state <= w_hold_stage ? S_HOLD : S_CRUSH;
                end
                S_CRUSH: begin
                    if (r_crush_depth <= 5'd1) begin
                        r_y     <= r_v;
                        r_state <= S_STAGE_END;
                    end else begin
                        if (r_feature_flags[1]) begin
                            r_lfsr <= w_lfsr_nx;
                        end
                        r_wet   <= w_cwet;
                        r_pm    <= pct_clamp(r_crush_mix);
                        r_state <= S_PCT_LD;
                    end
                end
                S_HOLD: begin
                    if (w_hold_bypass) begin
                        r_y     <= r_v;
                        r_state <= S_STAGE_END;
                    end else begin
                        r_c0 <= r_phase;
                        r_pm <= pct_clamp(r_ds_mix);
                        if (w_capture) begin
                            r_held  <= r_v;
                            r_phase <= 15'(w_pc - {1'b0, w_rate});
                        end else begin
                            r_phase <= w_pc[14:0];
                        end
                        if (r_feature_flags[0]) begin
                            r_state <= S_INT_LD;
                        end else begin
                            r_wet   <= WET_W'(w_capture ? r_v : r_held);
                            r_state <= S_PCT_LD;
                        end
                    end
                end
                S_INT_LD: begin
                    r_req   <= '{valid: 1'b1, op: MDU_LOAD, a: '0, b: '0, den: '0};
                    r_ret   <= S_INT_MAC;
                    r_state <= S_WAIT;
                end
                S_INT_MAC: begin
                    r_req   <= '{valid: 1'b1, op: MDU_MAC, a: w_int_a,
                                 b: MUL_W'(r_c0), den: '0};
                    r_ret   <= S_INT_DIV;
                    r_state <= S_WAIT;
                end
                S_INT_DIV: begin
                    r_req   <= '{valid: 1'b1, op: MDU_DIV, a: '0, b: '0,
                                 den: DEN_W'(w_rate)};
                    r_ret   <= S_INT_END;
                    r_state <= S_WAIT;
                end
                S_INT_END: begin
                    r_wet   <= w_int_wet;
                    r_state <= S_PCT_LD;
                end
                S_PCT_LD: begin
                    r_req   <= '{valid: 1'b1, op: MDU_LOAD, a: w_v100, b: '0, den: '0};
                    r_ret   <= S_PCT_MAC;
                    r_state <= S_WAIT;
                end
                S_PCT_MAC: begin
                    r_req   <= '{valid: 1'b1, op: MDU_MAC, a: w_pct_a,
                                 b: MUL_W'(r_pm), den: '0};
                    r_ret   <= S_PCT_DIV;
                    r_state <= S_WAIT;
                end
                S_PCT_DIV: begin
                    r_req   <= '{valid: 1'b1, op: MDU_DIV, a: '0, b: '0, den: DEN_PCT};
                    r_ret   <= S_PCT_END;
                    r_state <= S_WAIT;
                end
                S_PCT_END: begin
                    r_y     <= sat_s(w_acc);
                    r_state <= S_STAGE_END;
                end
                S_STAGE_END: begin
                    if (!r_pass) begin
                        r_pass <= 1'b1;
                        // In parallel mode both stages see the dry input.
                        if (w_parallel) begin
                            r_a <= r_y;
                        end else begin
                            r_v <= r_y;
                        end
                        r_state <= S_STAGE;
                    end else begin
                        if (w_parallel) begin
                            r_y <= sat_s(ACC_W'(w_avg));
                        end
                        r_state <= S_FIN_LD;
                    end
                end
                S_FIN_LD: begin
                    r_req   <= '{valid: 1'b1, op: MDU_LOAD, a: '0, b: '0, den: '0};
                    r_ret   <= S_FIN_M1;
                    r_state <= S_WAIT;
                end
                S_FIN_M1: begin
                    r_req   <= '{valid: 1'b1, op: MDU_MAC, a: ACC_W'(r_y), b: r_g, den: '0};
                    r_ret   <= S_FIN_M2;
                    r_state <= S_WAIT;
                end
                S_FIN_M2: begin
                    r_req   <= '{valid: 1'b1, op: MDU_MAC, a: ACC_W'(r_x),
                                 b: MUL_W'({PCT_FULL - w_p, 14'd0}), den: '0};
                    r_ret   <= S_FIN_DIV;
                    r_state <= S_WAIT;
                end
                S_FIN_DIV: begin
                    r_req   <= '{valid: 1'b1, op: MDU_DIV, a: '0, b: '0, den: DEN_FINAL};
                    r_ret   <= S_FIN_END;
                    r_state <= S_WAIT;
                end
                S_FIN_END: begin
                    r_res   <= sat_s(w_acc);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || !i_out_stall) begin
                        r_out   <= r_res;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_WAIT: begin
                    // A request is held for exactly one cycle.
                    r_req.valid <= 1'b0;
                    if (!r_req.valid && !w_busy) begin
                        r_state <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ov;
    assign o_sample_out = r_out;
    assign o_cfg_ready  = 1'b1;

    a_mdu_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_busy)
        else $error("arithmetic unit busy while no item is in flight");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("output item appeared outside the output state");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted item did not start the sequencer");

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != 32'd0)
        else $error("dither generator locked at zero");

endmodule
